// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/qau_pkg.sv =====
// Shared types, widths, operation and status codes for the quaternion unit.
// Depends on nothing; every RTL module imports it.
`timescale 1ns / 1ps
package qau_pkg;

  // Fixed-point format of every field: Q16.16 in 32 bits.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int LANES  = 4;
  localparam int ELEMS  = 9;

  // Internal widths derived from the format.
  localparam int PROD_W = 2 * DATA_W;
  localparam int RND_W  = PROD_W - FRAC_W;
  localparam int PAIR_W = RND_W + 2;
  localparam int SUM_W  = PAIR_W + 3;
  localparam int SSQ_W  = PROD_W + 1;
  localparam int RAD_W  = PROD_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = FRAC_W + 1;
  localparam int REM_W  = ROOT_W + QUO_W;

  // Operation codes.
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_SCALE = 3'd1;
  localparam logic [2:0] OP_CONJ  = 3'd2;
  localparam logic [2:0] OP_MAG   = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;
  localparam logic [2:0] OP_ROT   = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] scale_factor;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_0;
    logic signed [DATA_W-1:0] res_1;
    logic signed [DATA_W-1:0] res_2;
    logic signed [DATA_W-1:0] res_3;
    logic signed [DATA_W-1:0] res_4;
    logic signed [DATA_W-1:0] res_5;
    logic signed [DATA_W-1:0] res_6;
    logic signed [DATA_W-1:0] res_7;
    logic signed [DATA_W-1:0] res_8;
    logic [1:0]               status;
  } res_t;

  // Clamps a wide sum to the word range; the top bit reports a clamp.
  function automatic logic [DATA_W:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = '0;
    hi[DATA_W-2:0] = '1;
    lo = ~hi;
    if (v > hi) begin
      return {1'b1, hi[DATA_W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[DATA_W-1:0]};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

endpackage

// ===== rtl/quaternion_arith_unit.sv =====
// Quaternion arithmetic unit: one word accepted per cycle, busy never rises.
// Every operation takes the same path to the result strobe done:
// five front stages, the 33-stage square root, the 18-stage divider
// (input register and 17 quotient steps) and the output register.
// Throughput is one word per cycle; the receiver cannot stall the pipeline.
// Synchronous reset clears every valid bit; data registers are not reset.
// Depends on qau_pkg, qau_sqrt, qau_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_arith_unit import qau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

  // Side data carried past the root and divider.
  typedef struct packed {
    logic [2:0]       op;
    logic [LANES-1:0] neg;
    res_t             res;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] root;
  } dtag_t;

  localparam logic [ELEMS-1:0] DIAG = ELEMS'(9'b100010001);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]  ONE  = SUM_W'(1) << FRAC_W;

  function automatic logic signed [PAIR_W-1:0] ex(input logic signed [RND_W-1:0] v);
    return PAIR_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] apply_sign(input logic [QUO_W-1:0] q,
                                                   input logic neg);
    logic [DATA_W-1:0] m;
    m = DATA_W'(q);
    return neg ? -m : m;
  endfunction

  assign busy = 1'b0;

  // Stage 1: input register.
  logic v1;
  req_t r1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    r1 <= req;
  end

  // Operand selection: B for multiply, the factor for scale, A otherwise.
  logic signed [DATA_W-1:0] qa1 [LANES];
  logic signed [DATA_W-1:0] sb1 [LANES];
  always_comb begin
    qa1[0] = r1.a_w;
    qa1[1] = r1.a_x;
    qa1[2] = r1.a_y;
    qa1[3] = r1.a_z;
    case (r1.req_type)
      OP_MUL: begin
        sb1[0] = r1.b_w;
        sb1[1] = r1.b_x;
        sb1[2] = r1.b_y;
        sb1[3] = r1.b_z;
      end
      OP_SCALE: begin
        for (int j = 0; j < LANES; j++) sb1[j] = r1.scale_factor;
      end
      default: begin
        for (int j = 0; j < LANES; j++) sb1[j] = qa1[j];
      end
    endcase
  end

  // Stage 2: sixteen exact products.
  logic v2;
  logic [2:0] op2;
  logic signed [DATA_W-1:0] a2 [LANES];
  logic signed [PROD_W-1:0] prod2 [LANES][LANES];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2 <= r1.req_type;
    for (int i = 0; i < LANES; i++) begin
      a2[i] <= qa1[i];
      for (int j = 0; j < LANES; j++) begin
        prod2[i][j] <= PROD_W'(qa1[i]) * PROD_W'(sb1[j]);
      end
    end
  end

  // Stage 3: products rounded half up; squares paired for the magnitude.
  logic v3;
  logic [2:0] op3;
  logic signed [DATA_W-1:0] a3 [LANES];
  logic signed [RND_W-1:0] rp3 [LANES][LANES];
  logic [PROD_W-1:0] sqp3 [2];
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    op3 <= op2;
    for (int i = 0; i < LANES; i++) begin
      a3[i] <= a2[i];
      for (int j = 0; j < LANES; j++) begin
        rp3[i][j] <= RND_W'((prod2[i][j] + HALF) >>> FRAC_W);
      end
    end
    sqp3[0] <= prod2[0][0] + prod2[1][1];
    sqp3[1] <= prod2[2][2] + prod2[3][3];
  end

  // Stage 4: the two partial sums of every result element.
  logic signed [PAIR_W-1:0] pa_n [ELEMS];
  logic signed [PAIR_W-1:0] pb_n [ELEMS];
  logic dbl_n;
  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      pa_n[e] = '0;
      pb_n[e] = '0;
    end
    dbl_n = 1'b0;
    case (op3)
      OP_MUL: begin
        pa_n[0] = ex(rp3[0][0]) - ex(rp3[1][1]);
        pb_n[0] = -ex(rp3[2][2]) - ex(rp3[3][3]);
        pa_n[1] = ex(rp3[0][1]) + ex(rp3[1][0]);
        pb_n[1] = ex(rp3[2][3]) - ex(rp3[3][2]);
        pa_n[2] = ex(rp3[0][2]) - ex(rp3[1][3]);
        pb_n[2] = ex(rp3[2][0]) + ex(rp3[3][1]);
        pa_n[3] = ex(rp3[0][3]) + ex(rp3[1][2]);
        pb_n[3] = ex(rp3[3][0]) - ex(rp3[2][1]);
      end
      OP_SCALE: begin
        for (int i = 0; i < LANES; i++) pa_n[i] = ex(rp3[i][0]);
      end
      OP_CONJ: begin
        pa_n[0] = PAIR_W'(a3[0]);
        for (int i = 1; i < LANES; i++) pa_n[i] = -PAIR_W'(a3[i]);
      end
      OP_ROT: begin
        dbl_n   = 1'b1;
        pa_n[0] = ex(rp3[0][0]);
        pb_n[0] = ex(rp3[1][1]);
        pa_n[1] = ex(rp3[1][2]);
        pb_n[1] = -ex(rp3[0][3]);
        pa_n[2] = ex(rp3[1][3]);
        pb_n[2] = ex(rp3[0][2]);
        pa_n[3] = ex(rp3[1][2]);
        pb_n[3] = ex(rp3[0][3]);
        pa_n[4] = ex(rp3[0][0]);
        pb_n[4] = ex(rp3[2][2]);
        pa_n[5] = ex(rp3[2][3]);
        pb_n[5] = -ex(rp3[0][1]);
        pa_n[6] = ex(rp3[1][3]);
        pb_n[6] = -ex(rp3[0][2]);
        pa_n[7] = ex(rp3[2][3]);
        pb_n[7] = ex(rp3[0][1]);
        pa_n[8] = ex(rp3[0][0]);
        pb_n[8] = ex(rp3[3][3]);
      end
      default: ;
    endcase
  end

  logic v4;
  logic [2:0] op4;
  logic dbl4;
  logic signed [DATA_W-1:0] a4 [LANES];
  logic signed [PAIR_W-1:0] pa4 [ELEMS];
  logic signed [PAIR_W-1:0] pb4 [ELEMS];
  logic [SSQ_W-1:0] ssq4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    op4  <= op3;
    dbl4 <= dbl_n;
    for (int i = 0; i < LANES; i++) a4[i] <= a3[i];
    for (int e = 0; e < ELEMS; e++) begin
      pa4[e] <= pa_n[e];
      pb4[e] <= pb_n[e];
    end
    ssq4 <= SSQ_W'(sqp3[0]) + SSQ_W'(sqp3[1]);
  end

  // Stage 5: final sums, doubling and offset for the matrix, saturation.
  logic signed [SUM_W-1:0] sum5 [ELEMS];
  logic [DATA_W:0] sw5 [ELEMS];
  logic [DATA_W-1:0] val5 [ELEMS];
  logic sat_any5;
  logic [LANES-1:0] neg5;
  side_t side_n;
  always_comb begin
    sat_any5 = 1'b0;
    for (int e = 0; e < ELEMS; e++) begin
      sum5[e] = SUM_W'(pa4[e]) + SUM_W'(pb4[e]);
      if (dbl4) begin
        sum5[e] = (sum5[e] <<< 1) - (DIAG[e] ? ONE : SUM_W'(0));
      end
      sw5[e]  = sat_word(sum5[e]);
      val5[e] = sw5[e][DATA_W-1:0];
      sat_any5 = sat_any5 | sw5[e][DATA_W];
    end
    for (int i = 0; i < LANES; i++) neg5[i] = a4[i][DATA_W-1];
    // Normalize carries the absolute components to the divider.
    if (op4 == OP_NORM) begin
      for (int i = 0; i < LANES; i++) begin
        val5[i] = neg5[i] ? -a4[i] : a4[i];
      end
      sat_any5 = 1'b0;
    end
    side_n.op  = op4;
    side_n.neg = neg5;
    side_n.res = {val5[0], val5[1], val5[2], val5[3], val5[4], val5[5], val5[6],
                  val5[7], val5[8], (sat_any5 ? ST_SAT : ST_OK)};
  end

  logic v5;
  side_t side5;
  logic [SSQ_W-1:0] ssq5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    side5 <= side_n;
    ssq5  <= ssq4;
  end

  // Square root of the sum of squares.
  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t sq_side;
  qau_sqrt #(
    .RAD_BITS (RAD_W),
    .TAG_W    ($bits(side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_rad    (RAD_W'(ssq5)),
    .in_tag    (side5),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_side)
  );

  // Numerators for normalize: |a| scaled up plus half the magnitude.
  logic [DATA_W-1:0] abs_l [LANES];
  logic [LANES-1:0][REM_W-1:0] num_d;
  dtag_t dtag_in;
  always_comb begin
    abs_l[0] = sq_side.res.res_0;
    abs_l[1] = sq_side.res.res_1;
    abs_l[2] = sq_side.res.res_2;
    abs_l[3] = sq_side.res.res_3;
    for (int i = 0; i < LANES; i++) begin
      num_d[i] = (REM_W'(abs_l[i]) << FRAC_W) + REM_W'(sq_root >> 1);
    end
    dtag_in.side = sq_side;
    dtag_in.root = sq_root;
  end

  logic dv_valid;
  logic [LANES-1:0][QUO_W-1:0] quo;
  dtag_t dt;
  qau_div #(
    .NLANE (LANES),
    .DEN_W (ROOT_W),
    .QB_W  (QUO_W),
    .TAG_W ($bits(dtag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_num    (num_d),
    .in_den    (sq_root),
    .in_tag    (dtag_in),
    .out_valid (dv_valid),
    .out_quo   (quo),
    .out_tag   (dt)
  );

  // Final selection of magnitude and normalize results.
  res_t fin;
  always_comb begin
    fin = dt.side.res;
    case (dt.side.op)
      OP_MAG: begin
        fin = '0;
        if (dt.root[ROOT_W-1:DATA_W-1] != '0) begin
          fin.res_0  = {1'b0, {(DATA_W-1){1'b1}}};
          fin.status = ST_SAT;
        end else begin
          fin.res_0  = dt.root[DATA_W-1:0];
          fin.status = ST_OK;
        end
      end
      OP_NORM: begin
        fin = '0;
        if (dt.root == '0) begin
          fin.status = ST_ZERO;
        end else begin
          fin.res_0 = apply_sign(quo[0], dt.side.neg[0]);
          fin.res_1 = apply_sign(quo[1], dt.side.neg[1]);
          fin.res_2 = apply_sign(quo[2], dt.side.neg[2]);
          fin.res_3 = apply_sign(quo[3], dt.side.neg[3]);
          fin.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    result <= fin;
  end

  // Conditions checked on every strobed result.
  logic st_known;
  logic norm_zero_ok;
  assign st_known = (result.status == ST_OK) || (result.status == ST_SAT) ||
                    (result.status == ST_ZERO);
  assign norm_zero_ok = (result.res_0 == '0) && (result.res_1 == '0) &&
                        (result.res_2 == '0) && (result.res_3 == '0);

  // Checks.
  `ASSERT_NEXT(a_valid_s12, clk, rst, v1, v2)
  `ASSERT_NEXT(a_valid_s45, clk, rst, v4, v5)
  `ASSERT_SAME(a_status_code, clk, rst, done, st_known)
  `ASSERT_SAME(a_zero_norm, clk, rst, done && result.status == ST_ZERO, norm_zero_ok)

endmodule

// ===== rtl/qau_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on qau_pkg for the default radicand width; a tag travels alongside.
`timescale 1ns / 1ps
module qau_sqrt import qau_pkg::*; #(
  parameter int RAD_BITS = RAD_W,
  parameter int TAG_W    = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [RAD_BITS-1:0]   in_rad,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [RAD_BITS/2-1:0] out_root,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int RT_W = RAD_BITS / 2;

  logic                v_q    [RT_W];
  logic [RAD_BITS-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]     root_q [RT_W];
  logic [TAG_W-1:0]    tag_q  [RT_W];

  genvar s;
  for (s = 0; s < RT_W; s++) begin : g_stage
    localparam int K = RT_W - 1 - s;
    logic                v_in;
    logic [RAD_BITS-1:0] rem_in;
    logic [RT_W-1:0]     root_in;
    logic [TAG_W-1:0]    tag_in;
    logic [RAD_BITS-1:0] trial;

    // The first stage starts from the radicand with an empty root.
    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    // Trial subtrahend for setting root bit K: (2*root + 2^K) * 2^K.
    assign trial = (RAD_BITS'(root_in) << (K + 1)) | (RAD_BITS'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
      if (rem_in >= trial) begin
        rem_q[s]  <= rem_in - trial;
        root_q[s] <= root_in | (RT_W'(1) << K);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
      tag_q[s] <= tag_in;
    end
  end

  assign out_valid = v_q[RT_W-1];
  assign out_root  = root_q[RT_W-1];
  assign out_tag   = tag_q[RT_W-1];

endmodule

// ===== rtl/qau_div.sv =====
// Pipelined restoring divider, several lanes sharing one divisor.
// Depends on qau_pkg for default widths; one quotient bit per register stage.
`timescale 1ns / 1ps
module qau_div import qau_pkg::*; #(
  parameter int NLANE = LANES,
  parameter int DEN_W = ROOT_W,
  parameter int QB_W  = QUO_W,
  parameter int TAG_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [NLANE-1:0][DEN_W+QB_W-1:0]   in_num,
  input  logic [DEN_W-1:0]                   in_den,
  input  logic [TAG_W-1:0]                   in_tag,
  output logic                               out_valid,
  output logic [NLANE-1:0][QB_W-1:0]         out_quo,
  output logic [TAG_W-1:0]                   out_tag
);

  localparam int RM_W = DEN_W + QB_W;

  // Input register so the numerator add in front stays off the first step.
  logic                          v0;
  logic [NLANE-1:0][RM_W-1:0]    num0;
  logic [DEN_W-1:0]              den0;
  logic [TAG_W-1:0]              tag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    num0 <= in_num;
    den0 <= in_den;
    tag0 <= in_tag;
  end

  logic                       v_q   [QB_W];
  logic [NLANE-1:0][RM_W-1:0] rem_q [QB_W];
  logic [NLANE-1:0][QB_W-1:0] quo_q [QB_W];
  logic [DEN_W-1:0]           den_q [QB_W];
  logic [TAG_W-1:0]           tag_q [QB_W];

  genvar s;
  for (s = 0; s < QB_W; s++) begin : g_stage
    localparam int K = QB_W - 1 - s;
    logic                       v_in;
    logic [NLANE-1:0][RM_W-1:0] rem_in;
    logic [NLANE-1:0][QB_W-1:0] quo_in;
    logic [DEN_W-1:0]           den_in;
    logic [TAG_W-1:0]           tag_in;
    logic [RM_W-1:0]            dk;

    if (s == 0) begin : g_first
      assign v_in   = v0;
      assign rem_in = num0;
      assign quo_in = '0;
      assign den_in = den0;
      assign tag_in = tag0;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // Divisor aligned to quotient bit K.
    assign dk = RM_W'(den_in) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
      for (int l = 0; l < NLANE; l++) begin
        if (rem_in[l] >= dk) begin
          rem_q[s][l] <= rem_in[l] - dk;
          quo_q[s][l] <= quo_in[l] | (QB_W'(1) << K);
        end else begin
          rem_q[s][l] <= rem_in[l];
          quo_q[s][l] <= quo_in[l];
        end
      end
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign out_valid = v_q[QB_W-1];
  assign out_quo   = quo_q[QB_W-1];
  assign out_tag   = tag_q[QB_W-1];

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the quaternion arithmetic unit.
// Depends on qau_pkg and quaternion_arith_unit; needs no files or arguments.
`timescale 1ns / 1ps
module tb_top;
  import qau_pkg::*;

  // Unused operation codes, which the unit answers with an all-zero word.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t req;
  res_t result;

  res_t pending_results[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  int gap_max = 15;

  quaternion_arith_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rounded fixed-point product: half an LSB added, then floored.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> FRAC_W;
  endfunction

  // Clamp to the signed word range, noting any clamp.
  function automatic logic signed [31:0] clamp_word(input longint v, inout bit hit);
    if (v > longint'(WMAX)) begin
      hit = 1'b1;
      return WMAX;
    end else if (v < longint'(WMIN)) begin
      hit = 1'b1;
      return WMIN;
    end
    return v[31:0];
  endfunction

  // Exact floor square root of the sum of squares of A.
  function automatic logic [63:0] quat_norm_len(input longint q[4]);
    logic [65:0] ssq;
    logic [65:0] trial;
    logic [65:0] root;
    logic [65:0] mag;
    ssq = '0;
    root = '0;
    for (int i = 0; i < 4; i++) begin
      mag = (q[i] < 0) ? 66'(-q[i]) : 66'(q[i]);
      ssq = ssq + mag * mag;
    end
    for (int b = 32; b >= 0; b--) begin
      trial = root | (66'd1 << b);
      if (trial * trial <= ssq) root = trial;
    end
    return root[63:0];
  endfunction

  // Expected result word for one request word.
  function automatic res_t quat_op_result(input req_t w);
    res_t r;
    longint a[4];
    longint b[4];
    longint f;
    longint e[9];
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic [63:0] mag;
    logic [63:0] num;
    longint q;
    bit hit;
    logic signed [31:0] v[9];
    a = '{longint'(w.a_w), longint'(w.a_x), longint'(w.a_y), longint'(w.a_z)};
    b = '{longint'(w.b_w), longint'(w.b_x), longint'(w.b_y), longint'(w.b_z)};
    f = longint'(w.scale_factor);
    hit = 1'b0;
    for (int i = 0; i < 9; i++) e[i] = 0;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      OP_MUL: begin
        e[0] = qmul(a[0], b[0]) - qmul(a[1], b[1]) - qmul(a[2], b[2]) - qmul(a[3], b[3]);
        e[1] = qmul(a[0], b[1]) + qmul(a[1], b[0]) + qmul(a[2], b[3]) - qmul(a[3], b[2]);
        e[2] = qmul(a[0], b[2]) - qmul(a[1], b[3]) + qmul(a[2], b[0]) + qmul(a[3], b[1]);
        e[3] = qmul(a[0], b[3]) + qmul(a[1], b[2]) - qmul(a[2], b[1]) + qmul(a[3], b[0]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) e[i] = qmul(a[i], f);
      end
      OP_CONJ: begin
        e[0] = a[0];
        for (int i = 1; i < 4; i++) e[i] = -a[i];
      end
      OP_MAG: begin
        e[0] = longint'(quat_norm_len(a));
      end
      OP_NORM: begin
        mag = quat_norm_len(a);
        if (mag == 0) begin
          r.status = ST_ZERO;
        end else begin
          for (int i = 0; i < 4; i++) begin
            num = (64'((a[i] < 0) ? -a[i] : a[i]) << FRAC_W) + (mag >> 1);
            q = longint'(num / mag);
            e[i] = (a[i] < 0) ? -q : q;
          end
        end
      end
      OP_ROT: begin
        ww = qmul(a[0], a[0]); xx = qmul(a[1], a[1]);
        yy = qmul(a[2], a[2]); zz = qmul(a[3], a[3]);
        xy = qmul(a[1], a[2]); xz = qmul(a[1], a[3]); yz = qmul(a[2], a[3]);
        wx = qmul(a[0], a[1]); wy = qmul(a[0], a[2]); wz = qmul(a[0], a[3]);
        e[0] = 2 * (ww + xx) - ONE; e[1] = 2 * (xy - wz); e[2] = 2 * (xz + wy);
        e[3] = 2 * (xy + wz); e[4] = 2 * (ww + yy) - ONE; e[5] = 2 * (yz - wx);
        e[6] = 2 * (xz - wy); e[7] = 2 * (yz + wx); e[8] = 2 * (ww + zz) - ONE;
      end
      default: ;
    endcase
    for (int i = 0; i < 9; i++) v[i] = clamp_word(e[i], hit);
    r.res_0 = v[0]; r.res_1 = v[1]; r.res_2 = v[2]; r.res_3 = v[3]; r.res_4 = v[4];
    r.res_5 = v[5]; r.res_6 = v[6]; r.res_7 = v[7]; r.res_8 = v[8];
    if (r.status == ST_OK && hit) r.status = ST_SAT;
    return r;
  endfunction

  // Record the expectation for every word the unit accepts.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_results.push_back(quat_op_result(req));
      words_in++;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    res_t x;
    if (!rst && done) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        errors++;
      end else begin
        x = pending_results.pop_front();
        check_field("res_0", x.res_0, result.res_0);
        check_field("res_1", x.res_1, result.res_1);
        check_field("res_2", x.res_2, result.res_2);
        check_field("res_3", x.res_3, result.res_3);
        check_field("res_4", x.res_4, result.res_4);
        check_field("res_5", x.res_5, result.res_5);
        check_field("res_6", x.res_6, result.res_6);
        check_field("res_7", x.res_7, result.res_7);
        check_field("res_8", x.res_8, result.res_8);
        check_field("status", 32'(x.status), 32'(result.status));
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("quaternion_arith_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request word after a random gap; start stays high afterwards.
  task automatic send_word(input req_t w);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= w;
    do @(posedge clk); while (busy);
  endtask

  function automatic req_t make_word(input logic [2:0] op, input logic [31:0] aw,
                                     input logic [31:0] ax, input logic [31:0] ay,
                                     input logic [31:0] az, input logic [31:0] bw,
                                     input logic [31:0] bx, input logic [31:0] by,
                                     input logic [31:0] bz, input logic [31:0] f);
    return '{op, aw, ax, ay, az, bw, bx, by, bz, f};
  endfunction

  // Field value: full range, near unity, small, medium, or an extreme.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
      3: return 32'($signed($urandom_range(0, 2 * 8192)) - 8192);
      4: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: begin
        case ($urandom_range(0, 3))
          0: return WMAX;
          1: return WMIN;
          2: return 32'd0;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    send_word(make_word(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0));
    send_word(make_word(OP_MUL, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    send_word(make_word(OP_MUL, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN, WMAX, WMIN, 0));
    send_word(make_word(OP_SCALE, ONE, -ONE, 32'h8000, 1, 0, 0, 0, 0, 2 * ONE));
    send_word(make_word(OP_SCALE, WMAX, WMIN, 1, -1, 0, 0, 0, 0, WMIN));
    send_word(make_word(OP_CONJ, WMIN, WMIN, WMAX, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CONJ, ONE, 1, -1, WMIN, 0, 0, 0, 0, 0));
    send_word(make_word(OP_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_MAG, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
    send_word(make_word(OP_MAG, WMAX, WMAX, WMAX, WMAX, 0, 0, 0, 0, 0));
    send_word(make_word(OP_NORM, 0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE));
    send_word(make_word(OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_word(make_word(OP_NORM, WMIN, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_NORM, WMAX, WMIN, 5, -7, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ROT, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ROT, 32'hb505, 0, 32'hb505, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ROT, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 0, 0));
    send_word(make_word(OP_SPARE_6, WMAX, WMIN, ONE, 1, 1, 2, 3, 4, 5));
    send_word(make_word(OP_SPARE_7, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    start <= 1'b0;
  endtask

  // Random words in phases with and without gaps between them.
  task automatic test_random(input int count);
    req_t w;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      w.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
      w.a_w = pick_value(); w.a_x = pick_value();
      w.a_y = pick_value(); w.a_z = pick_value();
      w.b_w = pick_value(); w.b_x = pick_value();
      w.b_y = pick_value(); w.b_z = pick_value();
      w.scale_factor = pick_value();
      if (w.req_type == OP_NORM && $urandom_range(0, 9) == 0) begin
        w.a_w = '0; w.a_x = '0; w.a_y = '0; w.a_z = '0;
      end
      send_word(w);
    end
    start <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request words over all six operations and the spare codes;", words_in);
    $display("%0d result words compared, %0d mismatches.", words_out, errors);
    if (errors == 0) begin
      $display("quaternion_arith_unit verification clean");
    end else begin
      $display("quaternion_arith_unit verification failed");
    end
    $finish;
  end

endmodule
